FILE: rtl/item_support_count_and_remap_defines.svh
`ifndef ITEM_SUPPORT_COUNT_AND_REMAP_DEFINES_SVH
`define ITEM_SUPPORT_COUNT_AND_REMAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ISCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ISCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/iscr_pkg.sv
`timescale 1ns / 1ps

package iscr_pkg;

  localparam int ITEM_W    = 14;
  localparam int OUT_W     = 13;
  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 48;
  localparam int PADDR_W   = 3;

  localparam logic [WORD_W-1:0] WORD_MAX    = {WORD_W{1'b1}};
  localparam logic [PROD_W-1:0] ROUND_UP    = PROD_W'({FRAC_W{1'b1}});

  localparam logic REG_IS_FRACTION = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef enum logic [1:0] {
    CMD_COUNT     = 2'd0,
    CMD_SEQ_START = 2'd1,
    CMD_FINALIZE  = 2'd2,
    CMD_REMAP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ITEM  = 2'd1,
    ST_NOT_FINAL = 2'd2
  } status_t;

  typedef struct packed {
    logic              is_fraction;
    logic [WORD_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic is_fraction;
  } thr_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } thr_rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] tag;
  } sup_entry_t;

endpackage

FILE: rtl/item_support_count_and_remap.sv
`timescale 1ns / 1ps
// Count, sequence start and remap pass through S_CNT, S_RMP or S_RESP after acceptance and
// then load their result into the output register once the output is not stalled; no new
// transaction is taken until the block is back in S_IDLE.
// Finalize: the threshold unit runs, then a walk reads each entry and writes one id per item.
// Reset (rst, synchronous): control clears at once, then a clearing pass over all ITEM_CAPACITY
// entries zeroes the support/tag memory; no transaction is taken until it ends.
module item_support_count_and_remap #(
  parameter int ITEM_CAPACITY = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iscr_pkg::PADDR_W-1:0]       paddr,
  input  logic [iscr_pkg::WORD_W-1:0]        pwdata,
  output logic [iscr_pkg::WORD_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         command,
  input  logic signed [iscr_pkg::ITEM_W-1:0] item,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [1:0]                         status,
  output logic                               kept,
  output logic signed [iscr_pkg::ITEM_W-1:0] mapped_item,
  output logic [iscr_pkg::OUT_W-1:0]         kept_count,
  output logic [iscr_pkg::WORD_W-1:0]        support_threshold,
  output logic [iscr_pkg::OUT_W-1:0]         largest_item,
  output logic [iscr_pkg::WORD_W-1:0]        sequences_seen
);
  import iscr_pkg::*;

  localparam int ADDR_W = $clog2(ITEM_CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(ITEM_CAPACITY - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CNT   = 7'b0000100,
    S_RMP   = 7'b0001000,
    S_THR   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  cfg_t     cfg;
  thr_req_t thr_req;
  thr_rsp_t thr_rsp;

  sup_entry_t              sup_mem [ITEM_CAPACITY];
  logic [ITEM_W-1:0]       ids_mem [ITEM_CAPACITY];
  sup_entry_t              sup_rd_data;
  logic [ITEM_W-1:0]       ids_rd_data;
  logic                    sup_rd_en, sup_wr_en, ids_rd_en, ids_wr_en;
  logic [ADDR_W-1:0]       sup_rd_addr, sup_wr_addr;
  sup_entry_t              sup_wr_data;
  logic [ITEM_W-1:0]       ids_wr_data;

  logic [WORD_W-1:0]       seq_count, seq_next;
  logic [ITEM_W-1:0]       max_item, max_next;
  logic [WORD_W-1:0]       thr_count, thr_count_next;
  logic [ITEM_W-1:0]       kept_total, kept_total_next;
  logic                    pending, pending_next;
  logic                    finalized, finalized_next;

  logic [ADDR_W-1:0]       clr_addr;
  logic [ADDR_W-1:0]       walk_addr;
  logic                    walk_run;
  logic                    walk_issue;
  logic                    walk_pv;
  logic [ADDR_W-1:0]       walk_pidx;
  logic                    walk_plast;
  logic                    walk_freq;

  logic                    accept;
  cmd_t                    cmd;
  logic [ITEM_W-1:0]       item_raw;
  logic                    item_neg;
  logic [ITEM_W-1:0]       item_mag;
  logic [WORD_W-1:0]       mag_ext;
  logic [WORD_W-1:0]       idx_ext;
  logic                    item_bad;
  logic [ADDR_W-1:0]       item_idx;
  logic                    cur_neg;
  logic [ADDR_W-1:0]       cur_idx;

  status_t                 res_status, res_status_c;
  logic                    res_kept, res_kept_c;
  logic [ITEM_W-1:0]       res_mapped, res_mapped_c;
  logic                    res_capture;
  logic                    res_ready;
  logic                    out_free;
  logic                    out_load;

  iscr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iscr_thresh u_thresh (
    .clk   (clk),
    .rst   (rst),
    .req   (thr_req),
    .value (cfg.value),
    .seqs  (seq_count),
    .rsp   (thr_rsp)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cmd       = cmd_t'(command);
  assign item_raw  = item;
  assign item_neg  = item_raw[ITEM_W-1];
  assign item_mag  = item_neg ? (ITEM_W'(0) - item_raw) : item_raw;
  assign mag_ext   = WORD_W'(item_mag);
  assign idx_ext   = mag_ext - WORD_W'(1);
  assign item_idx  = idx_ext[ADDR_W-1:0];
  assign item_bad  = (item_mag == '0) || (mag_ext > WORD_W'(ITEM_CAPACITY));

  assign out_free  = !rsp_valid || !rsp_stall;
  assign out_load  = res_ready && out_free;
  assign walk_issue = (state == S_WALK) && walk_run;
  assign walk_freq = (WORD_W'(walk_pidx) < WORD_W'(max_item)) &&
                     (sup_rd_data.count >= thr_count);

  always_comb begin
    state_next      = state;
    seq_next        = seq_count;
    max_next        = max_item;
    thr_count_next  = thr_count;
    kept_total_next = kept_total;
    pending_next    = pending;
    finalized_next  = finalized;
    sup_rd_en       = 1'b0;
    sup_rd_addr     = item_idx;
    sup_wr_en       = 1'b0;
    sup_wr_addr     = clr_addr;
    sup_wr_data     = '0;
    ids_rd_en       = 1'b0;
    ids_wr_en       = 1'b0;
    ids_wr_data     = '0;
    thr_req         = '0;
    res_status_c    = res_status;
    res_kept_c      = res_kept;
    res_mapped_c    = res_mapped;
    res_capture     = 1'b0;
    res_ready       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        sup_wr_en = 1'b1;
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_capture  = 1'b1;
          res_status_c = ST_OK;
          res_kept_c   = 1'b0;
          res_mapped_c = '0;
          unique case (cmd)
            CMD_COUNT: begin
              if (item_bad) begin
                res_status_c = ST_BAD_ITEM;
                state_next   = S_RESP;
              end else begin
                sup_rd_en  = 1'b1;
                max_next   = (item_mag > max_item) ? item_mag : max_item;
                state_next = S_CNT;
              end
            end
            CMD_SEQ_START: begin
              seq_next     = (seq_count == WORD_MAX) ? seq_count : seq_count + WORD_W'(1);
              pending_next = 1'b0;
              state_next   = S_RESP;
            end
            CMD_FINALIZE: begin
              thr_req.start       = 1'b1;
              thr_req.is_fraction = cfg.is_fraction;
              pending_next        = 1'b0;
              state_next          = S_THR;
            end
            CMD_REMAP: begin
              if (!finalized) begin
                res_status_c = ST_NOT_FINAL;
                state_next   = S_RESP;
              end else if (item_bad) begin
                res_status_c = ST_BAD_ITEM;
                state_next   = S_RESP;
              end else begin
                ids_rd_en  = 1'b1;
                state_next = S_RMP;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CNT: begin
        if (sup_rd_data.tag != seq_count) begin
          sup_wr_en         = 1'b1;
          sup_wr_addr       = cur_idx;
          sup_wr_data.tag   = seq_count;
          sup_wr_data.count = (sup_rd_data.count == WORD_MAX) ?
                              sup_rd_data.count : sup_rd_data.count + WORD_W'(1);
        end
        res_ready  = 1'b1;
        state_next = out_free ? S_IDLE : S_RESP;
      end
      S_RMP: begin
        res_capture = 1'b1;
        if (ids_rd_data == '0) begin
          if (cur_neg) begin
            pending_next = 1'b1;
          end
        end else begin
          pending_next = 1'b0;
          res_kept_c   = 1'b1;
          res_mapped_c = (cur_neg || pending) ? (ITEM_W'(0) - ids_rd_data) : ids_rd_data;
        end
        res_ready  = 1'b1;
        state_next = out_free ? S_IDLE : S_RESP;
      end
      S_THR: begin
        if (thr_rsp.done) begin
          thr_count_next  = thr_rsp.value;
          kept_total_next = '0;
          state_next      = S_WALK;
        end
      end
      S_WALK: begin
        sup_rd_en   = walk_issue;
        sup_rd_addr = walk_addr;
        if (walk_pv) begin
          ids_wr_en = 1'b1;
          if (walk_freq) begin
            kept_total_next = kept_total + ITEM_W'(1);
            ids_wr_data     = kept_total + ITEM_W'(1);
          end
          if (walk_plast) begin
            finalized_next = 1'b1;
            state_next     = S_RESP;
          end
        end
      end
      S_RESP: begin
        res_ready = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      seq_count  <= '0;
      max_item   <= '0;
      thr_count  <= '0;
      kept_total <= '0;
      pending    <= 1'b0;
      finalized  <= 1'b0;
      clr_addr   <= '0;
      walk_run   <= 1'b0;
      walk_pv    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      seq_count  <= seq_next;
      max_item   <= max_next;
      thr_count  <= thr_count_next;
      kept_total <= kept_total_next;
      pending    <= pending_next;
      finalized  <= finalized_next;
      walk_pv    <= walk_issue;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if ((state == S_THR) && thr_rsp.done) begin
        walk_run <= 1'b1;
      end else if (walk_issue && (walk_addr == LAST_IDX)) begin
        walk_run <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_neg <= item_neg;
      cur_idx <= item_idx;
    end
    if ((state == S_THR) && thr_rsp.done) begin
      walk_addr <= '0;
    end else if (walk_issue) begin
      walk_addr <= walk_addr + ADDR_W'(1);
    end
    walk_pidx  <= walk_addr;
    walk_plast <= (walk_addr == LAST_IDX);
    if (res_capture) begin
      res_status <= res_status_c;
      res_kept   <= res_kept_c;
      res_mapped <= res_mapped_c;
    end
    if (out_load) begin
      status            <= res_status_c;
      kept              <= res_kept_c;
      mapped_item       <= res_mapped_c;
      kept_count        <= kept_total_next[OUT_W-1:0];
      support_threshold <= thr_count_next;
      largest_item      <= max_next[OUT_W-1:0];
      sequences_seen    <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sup_wr_en) begin
      sup_mem[sup_wr_addr] <= sup_wr_data;
    end
    if (sup_rd_en) begin
      sup_rd_data <= sup_mem[sup_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ids_wr_en) begin
      ids_mem[walk_pidx] <= ids_wr_data;
    end
    if (ids_rd_en) begin
      ids_rd_data <= ids_mem[item_idx];
    end
  end

endmodule

FILE: rtl/iscr_cfg_regs.sv
`timescale 1ns / 1ps

module iscr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iscr_pkg::PADDR_W-1:0] paddr,
  input  logic [iscr_pkg::WORD_W-1:0]  pwdata,
  output logic [iscr_pkg::WORD_W-1:0]  prdata,
  output logic                        pready,
  output iscr_pkg::cfg_t              cfg
);
  import iscr_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_fraction <= 1'b0;
      cfg.value       <= WORD_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_IS_FRACTION: cfg.is_fraction <= pwdata[0];
        REG_THRESHOLD:   cfg.value       <= pwdata;
        default:         cfg.value       <= cfg.value;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IS_FRACTION: prdata = {{(WORD_W-1){1'b0}}, cfg.is_fraction};
      REG_THRESHOLD:   prdata = cfg.value;
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/iscr_thresh.sv
`timescale 1ns / 1ps

module iscr_thresh (
  input  logic                       clk,
  input  logic                       rst,
  input  iscr_pkg::thr_req_t         req,
  input  logic [iscr_pkg::WORD_W-1:0] value,
  input  logic [iscr_pkg::WORD_W-1:0] seqs,
  output iscr_pkg::thr_rsp_t         rsp
);
  import iscr_pkg::*;

  logic              mul_valid;
  logic              done;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0] rounded;
  logic [WORD_W-1:0] result;

  assign prod_c  = PROD_W'(value[FRAC_W-1:0]) * PROD_W'(seqs);
  assign rounded = prod + ROUND_UP;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul_valid <= req.start && req.is_fraction;
      done      <= (req.start && !req.is_fraction) || mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= prod_c;
    end
    if (req.start && !req.is_fraction) begin
      result <= value;
    end else if (mul_valid) begin
      result <= rounded[PROD_W-1:FRAC_W];
    end
  end

  assign rsp = '{done: done, value: result};

endmodule

FILE: rtl/iscr_checker.sv
`timescale 1ns / 1ps
`include "item_support_count_and_remap_defines.svh"

module iscr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_stall,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic [1:0]                         status,
  input logic                               kept,
  input logic signed [iscr_pkg::ITEM_W-1:0] mapped_item
);
  import iscr_pkg::*;

  `ISCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(mapped_item), "stalled transaction changed")
  `ISCR_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second transaction taken while busy")
  `ISCR_ASSERT_NOW(a_kept_ok, rsp_valid && kept, (status == ST_OK) && (mapped_item != '0), "kept item without ok status or id")
  `ISCR_ASSERT_NOW(a_drop_zero, rsp_valid && !kept, mapped_item == '0, "dropped item carries an id")

endmodule

bind item_support_count_and_remap iscr_checker u_iscr_checker (.*);
